// File: hdl/dss_pkg.sv
// Shared constants and types for the shortest-path block.
// No dependencies.
package dss_pkg;
  localparam int MaxVertices = 64;
  localparam int MaxEdges    = 1024;
  localparam int WeightBits  = 16;
  localparam int VertexBits  = $clog2(MaxVertices);
  localparam int EdgeAddrBits = $clog2(MaxEdges);
  localparam int EdgeCountBits = $clog2(MaxEdges + 1);
  localparam int DistBits    = 32;
  localparam int DeltaBits   = 16;
  localparam logic [DistBits-1:0] DistInf     = 32'hFFFF_FFFF;
  localparam logic [DistBits-1:0] DistMaxFin  = 32'hFFFF_FFFE;
  localparam logic [DeltaBits-1:0] DeltaReset = 16'd5;

  localparam logic CfgSource = 1'b0;
  localparam logic CfgDelta  = 1'b1;

  typedef logic [DistBits-1:0] dist_t;
endpackage

// File: hdl/dss_rem.sv
// Serial restoring remainder unit, one quotient bit per cycle.
// Depends on dss_pkg.
module dss_rem import dss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  dist_t                dividend,
  input  logic [DeltaBits-1:0] divisor,
  output logic                 done,
  output logic [DeltaBits-1:0] remainder
);
  logic [DistBits-1:0]  num;
  logic [DeltaBits:0]   rem;
  logic [5:0]           cnt;
  logic                 busy;
  logic [DeltaBits:0]   trial;

  always_comb begin
    trial = {rem[DeltaBits-1:0], num[DistBits-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      num  <= dividend;
      rem  <= '0;
      cnt  <= 6'(DistBits);
      done <= 1'b0;
    end else if (busy) begin
      num <= {num[DistBits-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) rem <= trial - {1'b0, divisor};
      else rem <= trial;
      cnt <= cnt - 6'd1;
      busy <= (cnt != 6'd1);
      done <= (cnt == 6'd1);
    end else begin
      done <= 1'b0;
    end
  end

  assign remainder = rem[DeltaBits-1:0];
endmodule

// File: hdl/delta_stepping_shortest_paths_top.sv
// Edges stream in one transfer per cycle and are stored until the edge marked
// tlast; that edge starts a bucketed shortest-path run from the source vertex,
// after which 64 results (one per vertex, in order) leave on the master side,
// each through EM_RD and EM_WAIT and then held in EM_HOLD until m_tready. Per
// bucket the run does a minimum scan over all vertices and a serial remainder
// step; per phase, a vertex scan and an edge scan in which a skipped edge goes
// through E0, E1 and a relaxed edge E0, E1, E2. Depends on dss_pkg and dss_rem.
module delta_stepping_shortest_paths_top import dss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // edge_from, edge_to, edge_weight, zero fill
  input  logic        s_tlast,  // last_edge
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // vertex_id, distance, reachable, edges_dropped
  output logic        m_tlast,  // last_result
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  typedef enum logic [3:0] {
    LOAD, INIT, FIND, DIV, SEL, HSEL, E0, E1, E2, EM_RD, EM_WAIT, EM_HOLD
  } state_t;

  state_t state;
  logic [VertexBits-1:0] source;
  logic [DeltaBits-1:0]  bucket_width;
  logic [DeltaBits-1:0]  delta;
  logic [EdgeCountBits-1:0] edge_count;
  logic overflow;

  logic [VertexBits-1:0] tail_mem [MaxEdges];
  logic [VertexBits-1:0] head_mem [MaxEdges];
  logic [WeightBits-1:0] wt_mem   [MaxEdges];
  dist_t dist_mem [MaxVertices];
  dist_t snap_mem [MaxVertices];

  logic [MaxVertices-1:0] known, bvalid, settled, active;
  logic [VertexBits-1:0] e_t, e_h;
  logic [WeightBits-1:0] e_w;
  dist_t dist_rd, snap_rd, dcur, mind, lo;
  logic known_rd, found, any, heavy, p_ok;
  logic [VertexBits:0] vcnt;
  logic [VertexBits-1:0] p_v, rd_addr;
  logic [EdgeCountBits-1:0] ecnt;
  logic [DistBits:0] hi, sum;
  dist_t relax_x;
  logic div_start, div_done;
  logic [DeltaBits-1:0] div_rem;
  logic scan_done, in_bucket, light;

  assign delta = (bucket_width == '0) ? DeltaBits'(1) : bucket_width;
  assign s_tready = (state == LOAD);
  assign dcur = known_rd ? dist_rd : DistInf;
  assign rd_addr = (state == E1) ? e_h : vcnt[VertexBits-1:0];
  assign scan_done = (vcnt == (VertexBits+1)'(MaxVertices)) && !p_ok;
  assign in_bucket = bvalid[p_v] && (dcur >= lo) && ({1'b0, dcur} < hi);
  assign light = ({{(DeltaBits-WeightBits){1'b0}}, e_w} <= delta);
  assign sum = {1'b0, snap_rd} + {{(DistBits+1-WeightBits){1'b0}}, e_w};
  assign relax_x = (sum > {1'b0, DistMaxFin}) ? DistMaxFin : sum[DistBits-1:0];
  assign div_start = (state == FIND) && scan_done && found;

  dss_rem u_rem (
    .clk(clk), .rst(rst), .start(div_start), .dividend(mind), .divisor(delta),
    .done(div_done), .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      source <= '0;
      bucket_width <= DeltaReset;
    end else if (cfg_we) begin
      if (cfg_index == CfgSource) source <= cfg_data[VertexBits-1:0];
      else bucket_width <= cfg_data[DeltaBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    e_t <= tail_mem[ecnt[EdgeAddrBits-1:0]];
    e_h <= head_mem[ecnt[EdgeAddrBits-1:0]];
    e_w <= wt_mem[ecnt[EdgeAddrBits-1:0]];
    dist_rd <= dist_mem[rd_addr];
    known_rd <= known[rd_addr];
    snap_rd <= snap_mem[e_t];
    if (state == LOAD && s_tvalid && edge_count < EdgeCountBits'(MaxEdges)) begin
      tail_mem[edge_count[EdgeAddrBits-1:0]] <= s_tdata[5:0];
      head_mem[edge_count[EdgeAddrBits-1:0]] <= s_tdata[11:6];
      wt_mem[edge_count[EdgeAddrBits-1:0]]   <= s_tdata[27:12];
    end
    if (state == INIT) dist_mem[source] <= '0;
    else if (state == E2 && relax_x < dcur) dist_mem[e_h] <= relax_x;
    if ((state == SEL && p_ok && in_bucket) || (state == HSEL && p_ok && settled[p_v]))
      snap_mem[p_v] <= dcur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
      edge_count <= '0;
      overflow <= 1'b0;
      m_tvalid <= 1'b0;
      known <= '0;
      bvalid <= '0;
      settled <= '0;
      active <= '0;
      vcnt <= '0;
      p_ok <= 1'b0;
      ecnt <= '0;
      found <= 1'b0;
      any <= 1'b0;
      heavy <= 1'b0;
    end else begin
      if (state == FIND || state == SEL || state == HSEL) begin
        p_v <= vcnt[VertexBits-1:0];
        p_ok <= (vcnt < (VertexBits+1)'(MaxVertices));
        if (vcnt < (VertexBits+1)'(MaxVertices)) vcnt <= vcnt + 1'b1;
      end
      case (state)
        LOAD: begin
          if (s_tvalid) begin
            if (edge_count < EdgeCountBits'(MaxEdges)) edge_count <= edge_count + 1'b1;
            else overflow <= 1'b1;
            if (s_tlast) state <= INIT;
          end
        end
        INIT: begin
          known <= {{(MaxVertices-1){1'b0}}, 1'b1} << source;
          bvalid <= {{(MaxVertices-1){1'b0}}, 1'b1} << source;
          vcnt <= '0;
          p_ok <= 1'b0;
          found <= 1'b0;
          state <= FIND;
        end
        FIND: begin
          if (p_ok && bvalid[p_v] && (!found || dcur < mind)) begin
            mind <= dcur;
            found <= 1'b1;
          end
          if (scan_done) begin
            vcnt <= '0;
            state <= found ? DIV : EM_RD;
          end
        end
        DIV: begin
          if (div_done) begin
            lo <= mind - {{(DistBits-DeltaBits){1'b0}}, div_rem};
            hi <= {1'b0, mind - {{(DistBits-DeltaBits){1'b0}}, div_rem}}
                  + {{(DistBits+1-DeltaBits){1'b0}}, delta};
            settled <= '0;
            active <= '0;
            any <= 1'b0;
            vcnt <= '0;
            state <= SEL;
          end
        end
        SEL: begin
          if (p_ok && in_bucket) begin
            active[p_v] <= 1'b1;
            bvalid[p_v] <= 1'b0;
            settled[p_v] <= 1'b1;
            any <= 1'b1;
          end
          if (scan_done) begin
            vcnt <= '0;
            ecnt <= '0;
            if (any) begin
              heavy <= 1'b0;
              state <= E0;
            end else begin
              active <= '0;
              state <= HSEL;
            end
          end
        end
        HSEL: begin
          if (p_ok && settled[p_v]) active[p_v] <= 1'b1;
          if (scan_done) begin
            vcnt <= '0;
            ecnt <= '0;
            heavy <= 1'b1;
            state <= E0;
          end
        end
        E0: begin
          if (ecnt == edge_count) begin
            active <= '0;
            any <= 1'b0;
            found <= 1'b0;
            state <= heavy ? FIND : SEL;
          end else begin
            state <= E1;
          end
        end
        E1: begin
          if (active[e_t] && (light != heavy)) state <= E2;
          else begin
            ecnt <= ecnt + 1'b1;
            state <= E0;
          end
        end
        E2: begin
          if (relax_x < dcur) begin
            known[e_h] <= 1'b1;
            bvalid[e_h] <= 1'b1;
          end
          ecnt <= ecnt + 1'b1;
          state <= E0;
        end
        EM_RD: state <= EM_WAIT;
        EM_WAIT: begin
          m_tdata <= {overflow, known_rd && dcur != DistInf, dcur, vcnt[VertexBits-1:0]};
          m_tlast <= (vcnt == (VertexBits+1)'(MaxVertices-1));
          m_tvalid <= 1'b1;
          state <= EM_HOLD;
        end
        EM_HOLD: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (vcnt == (VertexBits+1)'(MaxVertices-1)) begin
              edge_count <= '0;
              overflow <= 1'b0;
              vcnt <= '0;
              state <= LOAD;
            end else begin
              vcnt <= vcnt + 1'b1;
              state <= EM_RD;
            end
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

  a_out_only_emit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> state == EM_HOLD) else $error("result shown outside emit");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input taken during emit");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    edge_count <= EdgeCountBits'(MaxEdges)) else $error("edge count overrun");
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == DIV) else $error("remainder done outside bucket step");
  a_relax_active: assert property (@(posedge clk) disable iff (rst)
    state == E2 |-> active[e_t]) else $error("relaxing edge of inactive tail");
endmodule
